// ===== design/wemb_pkg.sv =====
`timescale 1ns / 1ps

package wemb_pkg;

    // default sizes of the block
    localparam int NUM_ROWS_DEF      = 1024;
    localparam int MAX_VALUE_DIM_DEF = 16;
    localparam int MAX_BAG_DIM_DEF   = 256;

    // field widths
    localparam int ROW_W    = 10;
    localparam int FEAT_W   = 4;
    localparam int WORD_W   = 16;
    localparam int PROD_W   = 32;
    localparam int SUM_W    = 40;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int VDIM_W     = 5;
    localparam int BDIM_W     = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_DIM = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BAG_DIM   = CFG_IDX_W'(1);

    // request kinds on tuser
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_ELEM = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    // control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic issue;    // start one feature of a bag element
        logic emit_rd;  // read one accumulator for output
        logic first;    // first element of the bag: overwrite
        logic row_ok;   // row in range, else product is zero
    } mac_ctrl_t;

endpackage

// ===== design/wemb_table.sv =====
`timescale 1ns / 1ps

module wemb_table #(
    parameter int DEPTH = wemb_pkg::NUM_ROWS_DEF * wemb_pkg::MAX_VALUE_DIM_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [wemb_pkg::WORD_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [wemb_pkg::WORD_W-1:0] rd_data
);

    logic [wemb_pkg::WORD_W-1:0] mem [DEPTH];
    logic [wemb_pkg::WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/wemb_mac.sv =====
`timescale 1ns / 1ps

module wemb_mac #(
    parameter int MAX_VALUE_DIM = wemb_pkg::MAX_VALUE_DIM_DEF,
    parameter int FW            = (MAX_VALUE_DIM > 1) ? $clog2(MAX_VALUE_DIM) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  wemb_pkg::mac_ctrl_t         ctrl,
    input  logic [FW-1:0]               addr,
    input  logic [wemb_pkg::WORD_W-1:0] weight,
    input  logic [wemb_pkg::WORD_W-1:0] tbl_data,
    output logic [wemb_pkg::SUM_W-1:0]  acc_data,
    output logic                        busy
);

    logic [wemb_pkg::SUM_W-1:0]  acc_mem [MAX_VALUE_DIM];
    logic [wemb_pkg::SUM_W-1:0]  acc_q_reg;
    logic [wemb_pkg::SUM_W-1:0]  acc_q2_reg;
    logic signed [wemb_pkg::PROD_W-1:0] prod_reg;
    logic [FW-1:0]               f1_reg;
    logic [FW-1:0]               f2_reg;
    logic                        v1_reg;
    logic                        v2_reg;
    logic                        first1_reg;
    logic                        first2_reg;
    logic                        ok1_reg;
    logic signed [wemb_pkg::PROD_W-1:0] mul;
    logic signed [wemb_pkg::PROD_W-1:0] prod;
    logic [wemb_pkg::SUM_W-1:0]  prod_ext;
    logic [wemb_pkg::SUM_W-1:0]  acc_new;

    // stage 0: accumulator read for mac or output
    always_ff @(posedge aclk) begin
        if (ctrl.issue || ctrl.emit_rd) begin
            acc_q_reg <= acc_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= ctrl.issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        f1_reg     <= addr;
        first1_reg <= ctrl.first;
        ok1_reg    <= ctrl.row_ok;
        f2_reg     <= f1_reg;
        first2_reg <= first1_reg;
        acc_q2_reg <= acc_q_reg;
        prod_reg   <= prod;
    end

    // stage 1: the shared multiplier, signed product kept apart from the zero select
    assign mul  = $signed(tbl_data) * $signed(weight);
    assign prod = ok1_reg ? mul : '0;

    // stage 2: add and write back, wraps modulo 2^40
    assign prod_ext = wemb_pkg::SUM_W'(prod_reg);
    assign acc_new  = first2_reg ? prod_ext : (acc_q2_reg + prod_ext);

    always_ff @(posedge aclk) begin
        if (v2_reg) begin
            acc_mem[f2_reg] <= acc_new;
        end
    end

    assign acc_data = acc_q_reg;
    assign busy     = v1_reg || v2_reg;

endmodule

// ===== design/weighted_embedding_bag_sum_core.sv =====
`timescale 1ns / 1ps
// a load beat leaves the block ready for the next beat
// a bag element beat goes through the accept, one table read per feature in use through
// the single shared multiply-accumulate unit, then a drain until the pipe is empty; a
// finished bag adds an accumulator read and an output register load per result beat;
// reset clears the sequencer, bag position and config (16 features in use, bag_dim 1);
// table and accumulator contents are not cleared and are undefined until written

module weighted_embedding_bag_sum_core #(
    parameter int NUM_ROWS      = wemb_pkg::NUM_ROWS_DEF,
    parameter int MAX_VALUE_DIM = wemb_pkg::MAX_VALUE_DIM_DEF,
    parameter int MAX_BAG_DIM   = wemb_pkg::MAX_BAG_DIM_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // row[9:0], feature[13:10], value[29:14], weight[45:30], zero[47:46]
    input  logic [wemb_pkg::S_DATA_W-1:0]   s_tdata,
    // req_type[0]
    input  logic                            s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_feature[3:0], sum[43:4], zero[47:44]
    output logic [wemb_pkg::M_DATA_W-1:0]   m_tdata,
    // last
    output logic                            m_tlast,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wemb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wemb_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH = NUM_ROWS * MAX_VALUE_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW    = (MAX_VALUE_DIM > 1) ? $clog2(MAX_VALUE_DIM) : 1;
    localparam int CW    = $clog2(MAX_VALUE_DIM + 1);
    localparam int BW    = $clog2(MAX_BAG_DIM + 1);

    // input fields
    logic [wemb_pkg::ROW_W-1:0]  s_row;
    logic [wemb_pkg::FEAT_W-1:0] s_feature;
    logic [wemb_pkg::WORD_W-1:0] s_value;
    logic [wemb_pkg::WORD_W-1:0] s_weight;

    assign s_row     = s_tdata[9:0];
    assign s_feature = s_tdata[13:10];
    assign s_value   = s_tdata[29:14];
    assign s_weight  = s_tdata[45:30];

    // config registers
    logic [wemb_pkg::VDIM_W-1:0] feat_cnt_reg;
    logic [wemb_pkg::BDIM_W-1:0] bag_dim_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            feat_cnt_reg <= wemb_pkg::VDIM_W'(16);
            bag_dim_reg  <= wemb_pkg::BDIM_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                wemb_pkg::CFG_VALUE_DIM: feat_cnt_reg <= cfg_data[wemb_pkg::VDIM_W-1:0];
                wemb_pkg::CFG_BAG_DIM:   bag_dim_reg  <= cfg_data[wemb_pkg::BDIM_W-1:0];
                default: ;
            endcase
        end
    end

    // effective dims: zero acts as one, large values clamp to the maximum
    logic [CW-1:0] vd_eff;
    logic [BW-1:0] bd_eff;

    always_comb begin
        if (feat_cnt_reg == '0) begin
            vd_eff = CW'(1);
        end else if (32'(feat_cnt_reg) > MAX_VALUE_DIM) begin
            vd_eff = CW'(MAX_VALUE_DIM);
        end else begin
            vd_eff = CW'(feat_cnt_reg);
        end
        if (bag_dim_reg == '0) begin
            bd_eff = BW'(1);
        end else if (32'(bag_dim_reg) > MAX_BAG_DIM) begin
            bd_eff = BW'(MAX_BAG_DIM);
        end else begin
            bd_eff = BW'(bag_dim_reg);
        end
    end

    // sequencer
    wemb_pkg::state_t state_reg;
    wemb_pkg::state_t state_next;
    logic [CW-1:0]    f_reg;
    logic [CW-1:0]    f_next;
    logic [CW-1:0]    vd_reg;
    logic [BW-1:0]    bag_pos_reg;
    logic             first_reg;
    logic             emit_reg;
    logic             row_ok_reg;
    logic [wemb_pkg::WORD_W-1:0] weight_reg;
    logic [AW-1:0]    base_reg;

    logic s_beat;
    logic elem_beat;
    logic load_beat;
    logic row_in_range;
    logic feat_in_range;
    logic f_at_end;
    logic bag_done;
    logic mac_busy;
    logic out_free;

    wemb_pkg::mac_ctrl_t mac_ctrl;
    logic               tbl_rd_en;
    logic [AW-1:0]      tbl_rd_addr;
    logic [AW-1:0]      tbl_wr_addr;
    logic [wemb_pkg::WORD_W-1:0] tbl_rd_data;
    logic [wemb_pkg::SUM_W-1:0]  acc_data;
    logic               out_load;

    assign s_beat        = s_tvalid && s_tready;
    assign elem_beat     = s_beat && (s_tuser == wemb_pkg::REQ_ELEM);
    assign load_beat     = s_beat && (s_tuser == wemb_pkg::REQ_LOAD);
    assign row_in_range  = 32'(s_row) < NUM_ROWS;
    assign feat_in_range = 32'(s_feature) < MAX_VALUE_DIM;
    assign f_at_end      = CW'(f_reg + CW'(1)) == vd_reg;
    assign bag_done      = (32'(bag_pos_reg) + 1) >= 32'(bd_eff);

    // result register is empty now or drains this cycle
    logic m_valid_reg;
    assign out_free = !m_valid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        f_next     = f_reg;
        case (state_reg)
            wemb_pkg::ST_IDLE: begin
                if (elem_beat) begin
                    state_next = wemb_pkg::ST_RUN;
                    f_next     = '0;
                end
            end
            wemb_pkg::ST_RUN: begin
                if (f_at_end) begin
                    state_next = wemb_pkg::ST_DRAIN;
                end else begin
                    f_next = CW'(f_reg + CW'(1));
                end
            end
            wemb_pkg::ST_DRAIN: begin
                // last write-back has landed once the pipe is empty
                if (!mac_busy) begin
                    state_next = emit_reg ? wemb_pkg::ST_EMIT_RD : wemb_pkg::ST_IDLE;
                    f_next     = '0;
                end
            end
            wemb_pkg::ST_EMIT_RD: begin
                if (out_free) begin
                    state_next = wemb_pkg::ST_EMIT_LD;
                end
            end
            wemb_pkg::ST_EMIT_LD: begin
                if (f_at_end) begin
                    state_next = wemb_pkg::ST_IDLE;
                end else begin
                    state_next = wemb_pkg::ST_EMIT_RD;
                    f_next     = CW'(f_reg + CW'(1));
                end
            end
            default: begin
                state_next = wemb_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready         = 1'b0;
        mac_ctrl.issue   = 1'b0;
        mac_ctrl.emit_rd = 1'b0;
        mac_ctrl.first   = first_reg;
        mac_ctrl.row_ok  = row_ok_reg;
        out_load         = 1'b0;
        case (state_reg)
            wemb_pkg::ST_IDLE:    s_tready         = 1'b1;
            wemb_pkg::ST_RUN:     mac_ctrl.issue   = 1'b1;
            wemb_pkg::ST_DRAIN:   ;
            wemb_pkg::ST_EMIT_RD: mac_ctrl.emit_rd = out_free;
            wemb_pkg::ST_EMIT_LD: out_load         = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= wemb_pkg::ST_IDLE;
            f_reg       <= '0;
            bag_pos_reg <= '0;
        end else begin
            state_reg <= state_next;
            f_reg     <= f_next;
            if (elem_beat) begin
                bag_pos_reg <= bag_done ? '0 : BW'(bag_pos_reg + BW'(1));
            end
        end
    end

    // per-element context latched at the input beat
    always_ff @(posedge aclk) begin
        if (elem_beat) begin
            vd_reg     <= vd_eff;
            first_reg  <= bag_pos_reg == '0;
            emit_reg   <= bag_done;
            row_ok_reg <= row_in_range;
            weight_reg <= s_weight;
            base_reg   <= AW'(32'(s_row) * MAX_VALUE_DIM);
        end
    end

    // embedding table: loads write at the input beat, elements read per feature
    assign tbl_wr_addr = AW'(32'(s_row) * MAX_VALUE_DIM + 32'(s_feature));
    assign tbl_rd_en   = mac_ctrl.issue;
    assign tbl_rd_addr = AW'(base_reg + AW'(f_reg));

    wemb_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (load_beat && row_in_range && feat_in_range),
        .wr_addr (tbl_wr_addr),
        .wr_data (s_value),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    // shared multiply-accumulate unit with the accumulator memory
    wemb_mac #(
        .MAX_VALUE_DIM (MAX_VALUE_DIM),
        .FW            (FW)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (mac_ctrl),
        .addr     (f_reg[FW-1:0]),
        .weight   (weight_reg),
        .tbl_data (tbl_rd_data),
        .acc_data (acc_data),
        .busy     (mac_busy)
    );

    // result register, decouples the output from the sequencer
    logic [wemb_pkg::FEAT_W-1:0] m_feature_reg;
    logic [wemb_pkg::SUM_W-1:0]  m_sum_reg;
    logic                        m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_feature_reg <= wemb_pkg::FEAT_W'(f_reg);
            m_sum_reg     <= acc_data;
            m_last_reg    <= f_at_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, m_sum_reg, m_feature_reg};
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    // result register must be free when a new result lands
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wemb_pkg::ST_EMIT_LD) |-> !m_valid_reg)
        else $error("result register overwritten");

    // first element of a bag overwrites the accumulator
    assert property (@(posedge aclk) disable iff (!aresetn)
        (elem_beat && (bag_pos_reg == '0)) |=> first_reg)
        else $error("bag start not flagged");

    // feature counter stays inside the row while issuing or emitting
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == wemb_pkg::ST_RUN) || (state_reg == wemb_pkg::ST_EMIT_RD) ||
         (state_reg == wemb_pkg::ST_EMIT_LD)) |-> (f_reg < vd_reg))
        else $error("feature counter out of range");

    // no new element starts while the mac pipe still holds work
    assert property (@(posedge aclk) disable iff (!aresetn)
        elem_beat |-> !mac_busy)
        else $error("element accepted with mac busy");
`endif

endmodule

// ===== tb/sv/weighted_embedding_bag_sum_core_tb.sv =====
`timescale 1ns / 1ps

module weighted_embedding_bag_sum_core_tb;
    import wemb_pkg::*;

    localparam int HALF_PERIOD   = 10;
    // longest stretch with no beat on any channel before we give up
    localparam int QUIET_LIMIT   = 5000;
    // room for a trailing element beat and its result emission to finish; leave margin
    localparam int SETTLE_CYCLES = 48;
    localparam int ROWS          = NUM_ROWS_DEF;
    localparam int FEATS         = MAX_VALUE_DIM_DEF;

    // index with no register behind it, writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = CFG_IDX_W'(3);

    localparam logic signed [WORD_W-1:0] Q_MIN = 16'sh8000;
    localparam logic signed [WORD_W-1:0] Q_MAX = 16'sh7fff;

    // one input beat, field by field
    typedef struct packed {
        logic                     req_type;
        logic [ROW_W-1:0]         row;
        logic [FEAT_W-1:0]        feature;
        logic signed [WORD_W-1:0] value;
        logic signed [WORD_W-1:0] weight;
    } bag_req_t;

    // one bag sum beat as it should leave the block
    typedef struct packed {
        logic [FEAT_W-1:0] feature;
        logic [SUM_W-1:0]  sum;
        logic              last;
    } bag_sum_t;

    // dut ports, all inputs known from time zero
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // predictor state: table, per-feature accumulators, bag position, registers
    logic signed [WORD_W-1:0] emb_words [0:ROWS-1][0:FEATS-1];
    logic [SUM_W-1:0]         acc_words [0:FEATS-1];
    int                       bag_count = 0;
    logic [VDIM_W-1:0]        vdim_reg  = VDIM_W'(16);
    logic [BDIM_W-1:0]        bdim_reg  = BDIM_W'(1);

    bag_req_t pending_reqs [$];
    bag_sum_t sums_due [$];
    bag_req_t on_bus;
    bag_sum_t due_sum;

    // rows with all features loaded, the only ones a random bag element names
    int ready_rows [$];

    int items_queued  = 0;
    int items_taken   = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;
    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;

    weighted_embedding_bag_sum_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #(HALF_PERIOD) aclk = 1'b1;
        #(HALF_PERIOD) aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // work one accepted beat through the predictor, queue any bag sums it finishes
    task automatic apply_request(input bag_req_t req);
        int                       vd;
        int                       bd;
        logic signed [PROD_W-1:0] prod;
        logic signed [SUM_W-1:0]  term;
        bag_sum_t                 res;
        if (req.req_type == REQ_LOAD) begin
            emb_words[req.row][req.feature] = req.value;
            return;
        end
        // zero acts as one, oversize clamps to the table width / bag limit
        vd = (vdim_reg == 0) ? 1 : ((vdim_reg > FEATS) ? FEATS : int'(vdim_reg));
        bd = (bdim_reg == 0) ? 1 : ((bdim_reg > MAX_BAG_DIM_DEF) ? MAX_BAG_DIM_DEF
                                                                 : int'(bdim_reg));
        for (int f = 0; f < vd; f++) begin
            // q8.8 times q8.8 is exact in 32 bits, widened to q24.16
            prod = emb_words[req.row][f] * req.weight;
            term = prod;
            acc_words[f] = (bag_count == 0) ? term : acc_words[f] + term;
        end
        bag_count++;
        if (bag_count >= bd) begin
            bag_count = 0;
            for (int f = 0; f < vd; f++) begin
                res.feature = FEAT_W'(f);
                res.sum     = acc_words[f];
                res.last    = (f == vd - 1);
                sums_due.push_back(res);
            end
        end
    endtask

    // driver: next beat from the pending queue, with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_request(on_bus);
                items_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                    on_bus = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, on_bus.weight, on_bus.value, on_bus.feature,
                                 on_bus.row};
                    s_tuser  <= on_bus.req_type;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: random backpressure, each result beat against the oldest bag sum due
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (sums_due.size() == 0) begin
                    report_mismatch($sformatf("result beat with no sum due, feature %0d",
                                              m_tdata[FEAT_W-1:0]));
                end else begin
                    due_sum = sums_due.pop_front();
                    if (m_tdata[FEAT_W-1:0] !== due_sum.feature)
                        report_mismatch($sformatf("feature %0d, want %0d",
                                                  m_tdata[FEAT_W-1:0], due_sum.feature));
                    if (m_tdata[FEAT_W +: SUM_W] !== due_sum.sum)
                        report_mismatch($sformatf("sum %h, want %h (feature %0d)",
                                                  m_tdata[FEAT_W +: SUM_W], due_sum.sum,
                                                  due_sum.feature));
                    if (m_tlast !== due_sum.last)
                        report_mismatch($sformatf("last %b, want %b (feature %0d)",
                                                  m_tlast, due_sum.last, due_sum.feature));
                end
            end
            m_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // watchdog on cycles where no channel moves a beat
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // mostly random words, one in ten at the q8.8 extremes
    function automatic logic signed [WORD_W-1:0] rand_word();
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? Q_MAX : Q_MIN;
        return WORD_W'($urandom);
    endfunction

    task automatic push_load(input int row, input int feat, input logic signed [WORD_W-1:0] val);
        bag_req_t req;
        req.req_type = REQ_LOAD;
        req.row      = ROW_W'(row);
        req.feature  = FEAT_W'(feat);
        req.value    = val;
        req.weight   = WORD_W'($urandom);   // unused on a load
        pending_reqs.push_back(req);
        items_queued++;
    endtask

    task automatic push_element(input int row, input logic signed [WORD_W-1:0] wgt);
        bag_req_t req;
        req.req_type = REQ_ELEM;
        req.row      = ROW_W'(row);
        req.feature  = FEAT_W'($urandom);   // feature and value unused on an element
        req.value    = WORD_W'($urandom);
        req.weight   = wgt;
        pending_reqs.push_back(req);
        items_queued++;
    endtask

    // load a whole row so bag elements may name it at any feature count
    task automatic fill_row(input int row);
        for (int f = 0; f < FEATS; f++)
            push_load(row, f, rand_word());
        ready_rows.push_back(row);
    endtask

    // random mix: row fills, stray single-word loads, bag elements on filled rows
    task automatic queue_random(input int n);
        int left;
        int pick;
        left = n;
        while (left > 0) begin
            pick = $urandom_range(99);
            if (ready_rows.size() == 0 || pick < 5) begin
                fill_row($urandom_range(ROWS - 1));
                left -= FEATS;
            end else if (pick < 20) begin
                push_load($urandom_range(ROWS - 1), $urandom_range(FEATS - 1), rand_word());
                left--;
            end else begin
                push_element(ready_rows[$urandom_range(ready_rows.size() - 1)], rand_word());
                left--;
            end
        end
    endtask

    // every beat taken, every sum seen, then let a trailing element finish inside
    task automatic wait_idle();
        while (items_taken != items_queued || sums_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_VALUE_DIM)
            vdim_reg = data[VDIM_W-1:0];
        else if (idx == CFG_BAG_DIM)
            bdim_reg = data[BDIM_W-1:0];
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset config: 16 features, one element per bag
        // row 0 holds alternating q8.8 extremes, so every product sign shows up
        for (int f = 0; f < FEATS; f++)
            push_load(0, f, (f % 2) ? Q_MAX : Q_MIN);
        ready_rows.push_back(0);
        push_element(0, Q_MIN);
        push_element(0, Q_MAX);
        push_element(0, WORD_W'(0));

        // feature count field reads zero and bag_dim zero: both act as one
        wait_idle();
        write_reg(CFG_VALUE_DIM, 9'h1e0);
        write_reg(CFG_BAG_DIM, 9'h000);
        write_reg(CFG_SPARE_IDX, 9'h1ff);
        push_load(ROWS - 1, 0, Q_MAX);
        push_element(ROWS - 1, Q_MIN);
        push_element(0, WORD_W'(-1));
        // feature above the count in use is still stored and shows up once it grows
        push_load(0, FEATS - 1, WORD_W'(1));
        push_element(ROWS - 1, Q_MAX);

        // full width, single element bags, no idling
        wait_idle();
        write_reg(CFG_VALUE_DIM, 9'd16);
        write_reg(CFG_BAG_DIM, 9'd1);
        queue_random(20);

        // short rows, bags of four, sender mostly idle
        wait_idle();
        snd_idle_pct = 77;
        write_reg(CFG_VALUE_DIM, 9'd5);
        write_reg(CFG_BAG_DIM, 9'd4);
        queue_random(20);

        // feature count above the table width clamps to 16, receiver mostly stalled
        wait_idle();
        snd_idle_pct  = 0;
        rcv_stall_pct = 77;
        write_reg(CFG_VALUE_DIM, 9'd31);
        write_reg(CFG_BAG_DIM, 9'd7);
        queue_random(20);

        // largest bag: flush any open bag with bag_dim one, then 256 max products
        // reach the largest magnitude the sum can take
        wait_idle();
        snd_idle_pct  = 33;
        rcv_stall_pct = 33;
        write_reg(CFG_VALUE_DIM, 9'd1);
        write_reg(CFG_BAG_DIM, 9'd1);
        push_load(0, 0, Q_MIN);
        push_element(0, rand_word());
        wait_idle();
        write_reg(CFG_BAG_DIM, 9'h1ff);     // clamps to 256
        repeat (MAX_BAG_DIM_DEF) push_element(0, Q_MIN);

        // config change in the middle of a bag: bag_dim drops below the count
        // so the next element closes it, the feature count grows at the same time
        wait_idle();
        write_reg(CFG_VALUE_DIM, 9'd3);
        write_reg(CFG_BAG_DIM, 9'd5);
        queue_random(15);
        push_element(ready_rows[0], rand_word());
        push_element(ready_rows[0], rand_word());
        wait_idle();
        write_reg(CFG_BAG_DIM, 9'd2);
        write_reg(CFG_VALUE_DIM, 9'd6);
        queue_random(15);

        // open bag at the end of the stream is never emitted
        wait_idle();
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        write_reg(CFG_BAG_DIM, 9'd100);
        repeat (3) push_element(ready_rows[$urandom_range(ready_rows.size() - 1)],
                                rand_word());

        wait_idle();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
